FILE: rtl/ksfp_pkg.sv
// Shared types, constants and the CRC-16 byte update for the key status frame parser.
// No dependencies.
`default_nettype none
package ksfp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int STATUS_LEN = 9;
    localparam int IDX_W = $clog2(STATUS_LEN);
    localparam int CFG_IDX_W = 3;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0] ID_MAX = 8'h0F;
    localparam logic [7:0] ANGLE_POS_MAX = 8'd90;
    localparam logic [7:0] ANGLE_NEG_MIN = 8'd166;  // -90 as an unsigned byte

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_TYPE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTH_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_LIMIT  = 3'd5;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_CRC_BAD  = 2'd1;
    localparam logic [1:0] ST_IGNORED  = 2'd2;

    typedef enum logic [8:0] {
        PH_HEAD0   = 9'b000000001,
        PH_HEAD1   = 9'b000000010,
        PH_VERSION = 9'b000000100,
        PH_TYPE    = 9'b000001000,
        PH_SEQ     = 9'b000010000,
        PH_LENGTH  = 9'b000100000,
        PH_BODY    = 9'b001000000,
        PH_CRCLO   = 9'b010000000,
        PH_CRCHI   = 9'b100000000
    } t_phase;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/key_status_frame_parser_crc16_top.sv
// Key status frame parser: byte-wide framing, CRC-16/CCITT-FALSE check, field decode.
// Depends on ksfp_pkg.
//
// Usage:
//   Received bytes arrive on the rx channel (i_rx_valid / o_rx_ready, i_rx_byte),
//   one byte per beat. The parser hunts for the two head bytes, checks version,
//   takes type, sequence, length, payload and a little-endian CRC.
//   When the CRC high byte is accepted, one result beat is produced on the res
//   channel (o_res_valid / i_res_ready) in the next cycle.
//   All other bytes produce no result.
//   Throughput: one byte per cycle unless a finished result is still waiting,
//   set by the byte-wide CRC update and the one-hot phase register.
//   The result sits in an output register; o_rx_ready is high while that register
//   is empty or being taken in the same cycle, so a stalled receiver holds the
//   parser only when a finished result is still waiting.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at the
//   clock edge; indexes 6 and 7 are ignored.
//   Synchronous active-low reset restores the register defaults, clears both
//   counters, empties the output register and returns the parser to head hunt.
`default_nettype none
module key_status_frame_parser_crc16_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ksfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                    i_cfg_data,
    input  wire logic                          i_rx_valid,
    output logic                               o_rx_ready,
    input  wire logic [7:0]                    i_rx_byte,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic [1:0]                         o_frame_status,
    output logic [3:0]                         o_remote_id,
    output logic [7:0]                         o_auth_result,
    output logic [7:0]                         o_zone_code,
    output logic [7:0]                         o_event_code,
    output logic [15:0]                        o_distance_mm,
    output logic signed [7:0]                  o_angle_deg,
    output logic [7:0]                         o_state_flags,
    output logic [7:0]                         o_signal_quality,
    output logic [7:0]                         o_frame_sequence,
    output logic [31:0]                        o_crc_error_total,
    output logic [31:0]                        o_status_total
);

    logic [7:0] r_head_first, r_head_second, r_version, r_status_type;
    logic [7:0] r_auth_limit, r_zone_limit;

    ksfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_msg_type, n_msg_type;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_idx, n_idx;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [31:0] r_err_cnt, n_err_cnt;
    logic [31:0] r_stat_cnt, n_stat_cnt;
    logic [7:0]  r_body [ksfp_pkg::STATUS_LEN];

    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_status;
    logic [71:0] r_out_body;
    logic [7:0]  r_out_seq;
    logic [31:0] r_out_err, r_out_stat;

    logic        w_fire, w_emit, w_body_wr, w_restart, w_good;
    logic [7:0]  w_b;
    logic [15:0] w_crc_next;
    logic [1:0]  w_status;
    logic [71:0] w_body_out;

    assign w_b        = i_rx_byte;
    assign o_rx_ready = !r_out_valid || i_res_ready;
    assign w_fire     = i_rx_valid && o_rx_ready;
    assign w_crc_next = ksfp_pkg::crc_feed(r_crc, w_b);

    assign w_good = (r_msg_type == r_status_type)
                 && (r_len == 8'(ksfp_pkg::STATUS_LEN))
                 && (r_body[0] <= ksfp_pkg::ID_MAX)
                 && (r_body[1] <= r_auth_limit)
                 && (r_body[2] <= r_zone_limit)
                 && ((r_body[6] <= ksfp_pkg::ANGLE_POS_MAX)
                     || (r_body[6] >= ksfp_pkg::ANGLE_NEG_MIN));

    always_comb begin
        n_phase    = r_phase;
        n_msg_type = r_msg_type;
        n_seq      = r_seq;
        n_len      = r_len;
        n_idx      = r_idx;
        n_crc      = r_crc;
        n_crc_lo   = r_crc_lo;
        n_err_cnt  = r_err_cnt;
        n_stat_cnt = r_stat_cnt;
        w_emit     = 1'b0;
        w_body_wr  = 1'b0;
        w_restart  = 1'b0;
        w_status   = ksfp_pkg::ST_IGNORED;
        w_body_out = '0;
        if (w_fire) begin
            case (r_phase)
                ksfp_pkg::PH_HEAD0: begin
                    if (w_b == r_head_first) n_phase = ksfp_pkg::PH_HEAD1;
                end
                ksfp_pkg::PH_HEAD1: begin
                    if (w_b == r_head_second) begin
                        n_crc   = ksfp_pkg::CRC_INIT;
                        n_phase = ksfp_pkg::PH_VERSION;
                    end else begin
                        w_restart = 1'b1;
                    end
                end
                ksfp_pkg::PH_VERSION: begin
                    if (w_b == r_version) begin
                        n_crc   = w_crc_next;
                        n_phase = ksfp_pkg::PH_TYPE;
                    end else begin
                        w_restart = 1'b1;
                    end
                end
                ksfp_pkg::PH_TYPE: begin
                    n_msg_type = w_b;
                    n_crc      = w_crc_next;
                    n_phase    = ksfp_pkg::PH_SEQ;
                end
                ksfp_pkg::PH_SEQ: begin
                    n_seq   = w_b;
                    n_crc   = w_crc_next;
                    n_phase = ksfp_pkg::PH_LENGTH;
                end
                ksfp_pkg::PH_LENGTH: begin
                    if (w_b <= 8'(ksfp_pkg::MAX_PAYLOAD)) begin
                        n_len   = w_b;
                        n_idx   = '0;
                        n_crc   = w_crc_next;
                        n_phase = (w_b == 8'd0) ? ksfp_pkg::PH_CRCLO : ksfp_pkg::PH_BODY;
                    end else begin
                        w_restart = 1'b1;
                    end
                end
                ksfp_pkg::PH_BODY: begin
                    w_body_wr = (r_idx < 8'(ksfp_pkg::STATUS_LEN));
                    n_idx     = r_idx + 8'd1;
                    n_crc     = w_crc_next;
                    if (n_idx >= r_len) n_phase = ksfp_pkg::PH_CRCLO;
                end
                ksfp_pkg::PH_CRCLO: begin
                    n_crc_lo = w_b;
                    n_phase  = ksfp_pkg::PH_CRCHI;
                end
                ksfp_pkg::PH_CRCHI: begin
                    w_emit    = 1'b1;
                    w_restart = 1'b1;
                    if ({w_b, r_crc_lo} != r_crc) begin
                        n_err_cnt = r_err_cnt + 32'd1;
                        w_status  = ksfp_pkg::ST_CRC_BAD;
                    end else if (w_good) begin
                        n_stat_cnt = r_stat_cnt + 32'd1;
                        w_status   = ksfp_pkg::ST_ACCEPTED;
                        w_body_out = {r_body[8], r_body[7], r_body[6], r_body[5], r_body[4],
                                      r_body[3], r_body[2], r_body[1], 4'h0, r_body[0][3:0]};
                    end
                end
                default: w_restart = 1'b1;
            endcase
            if (w_restart) begin
                n_len    = '0;
                n_idx    = '0;
                n_crc    = ksfp_pkg::CRC_INIT;
                n_crc_lo = '0;
                n_phase  = (w_b == r_head_first) ? ksfp_pkg::PH_HEAD1 : ksfp_pkg::PH_HEAD0;
            end
        end
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_res_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_first  <= 8'hAA;
            r_head_second <= 8'h55;
            r_version     <= 8'd1;
            r_status_type <= 8'd1;
            r_auth_limit  <= 8'd2;
            r_zone_limit  <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ksfp_pkg::CFG_HEAD_FIRST:  r_head_first  <= i_cfg_data;
                ksfp_pkg::CFG_HEAD_SECOND: r_head_second <= i_cfg_data;
                ksfp_pkg::CFG_VERSION:     r_version     <= i_cfg_data;
                ksfp_pkg::CFG_STATUS_TYPE: r_status_type <= i_cfg_data;
                ksfp_pkg::CFG_AUTH_LIMIT:  r_auth_limit  <= i_cfg_data;
                ksfp_pkg::CFG_ZONE_LIMIT:  r_zone_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ksfp_pkg::PH_HEAD0;
            r_msg_type  <= '0;
            r_seq       <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_crc       <= ksfp_pkg::CRC_INIT;
            r_crc_lo    <= '0;
            r_err_cnt   <= '0;
            r_stat_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_msg_type  <= n_msg_type;
            r_seq       <= n_seq;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_crc       <= n_crc;
            r_crc_lo    <= n_crc_lo;
            r_err_cnt   <= n_err_cnt;
            r_stat_cnt  <= n_stat_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_body_wr) begin
            r_body[r_idx[ksfp_pkg::IDX_W-1:0]] <= w_b;
        end
        if (w_emit) begin
            r_out_status <= w_status;
            r_out_body   <= w_body_out;
            r_out_seq    <= r_seq;
            r_out_err    <= n_err_cnt;
            r_out_stat   <= n_stat_cnt;
        end
    end

    assign o_res_valid       = r_out_valid;
    assign o_frame_status    = r_out_status;
    assign o_remote_id       = r_out_body[3:0];
    assign o_auth_result     = r_out_body[15:8];
    assign o_zone_code       = r_out_body[23:16];
    assign o_event_code      = r_out_body[31:24];
    assign o_distance_mm     = r_out_body[47:32];
    assign o_angle_deg       = $signed(r_out_body[55:48]);
    assign o_state_flags     = r_out_body[63:56];
    assign o_signal_quality  = r_out_body[71:64];
    assign o_frame_sequence  = r_out_seq;
    assign o_crc_error_total = r_out_err;
    assign o_status_total    = r_out_stat;

endmodule
`default_nettype wire

FILE: rtl/ksfp_checker.sv
// Port-level assertions for the key status frame parser, bound to the top level.
// Depends on ksfp_pkg and key_status_frame_parser_crc16_top.
`default_nettype none
module ksfp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_res_valid,
    input wire logic        i_res_ready,
    input wire logic [1:0]  o_frame_status,
    input wire logic [3:0]  o_remote_id,
    input wire logic [7:0]  o_auth_result,
    input wire logic [31:0] o_status_total
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_status_total))
        else $error("result beat dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_frame_status <= ksfp_pkg::ST_IGNORED)
        else $error("unknown frame status code");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_frame_status != ksfp_pkg::ST_ACCEPTED
            |-> o_remote_id == 4'd0 && o_auth_result == 8'd0)
        else $error("decoded fields nonzero on a rejected frame");

endmodule

bind key_status_frame_parser_crc16_top ksfp_checker u_ksfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_frame_status (o_frame_status),
    .o_remote_id    (o_remote_id),
    .o_auth_result  (o_auth_result),
    .o_status_total (o_status_total)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for key_status_frame_parser_crc16_top: byte stream in, frame reports out.
// Holds a frame tracker that predicts every report; depends on ksfp_pkg and the RTL top.
`default_nettype none
module tb_top;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [ksfp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [ksfp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  remote_id;
        logic [7:0]  auth_result;
        logic [7:0]  zone_code;
        logic [7:0]  event_code;
        logic [15:0] distance_mm;
        logic [7:0]  angle_deg;
        logic [7:0]  state_flags;
        logic [7:0]  signal_quality;
        logic [7:0]  frame_seq;
        logic [31:0] crc_error_total;
        logic [31:0] status_total;
    } t_frame_report;

    class t_lock_frame_tracker;
        logic [7:0] reg_head_first, reg_head_second, reg_version;
        logic [7:0] reg_status_type, reg_auth_limit, reg_zone_limit;
        ksfp_pkg::t_phase phase;
        logic [7:0] msg_type, seq_byte, body_len, body_idx;
        logic [7:0] body [ksfp_pkg::STATUS_LEN];
        logic [15:0] crc_acc, crc_rx;
        logic [31:0] crc_errors, status_frames;
        t_frame_report pending [$];
        int mismatches;

        function new();
            reg_head_first = 8'hAA;
            reg_head_second = 8'h55;
            reg_version = 8'h01;
            reg_status_type = 8'h01;
            reg_auth_limit = 8'h02;
            reg_zone_limit = 8'h03;
            phase = ksfp_pkg::PH_HEAD0;
            msg_type = '0;
            seq_byte = '0;
            body_len = '0;
            body_idx = '0;
            foreach (body[i]) body[i] = '0;
            crc_acc = ksfp_pkg::CRC_INIT;
            crc_rx = '0;
            crc_errors = '0;
            status_frames = '0;
            mismatches = 0;
        endfunction

        // MSB-first bitwise form of CRC-16/CCITT-FALSE
        static function logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            logic fb;
            c = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ b[i];
                c = {c[14:0], 1'b0};
                if (fb) c = c ^ ksfp_pkg::CRC_POLY;
            end
            return c;
        endfunction

        function void write_reg(logic [ksfp_pkg::CFG_IDX_W-1:0] idx, logic [7:0] v);
            case (idx)
                ksfp_pkg::CFG_HEAD_FIRST:  reg_head_first = v;
                ksfp_pkg::CFG_HEAD_SECOND: reg_head_second = v;
                ksfp_pkg::CFG_VERSION:     reg_version = v;
                ksfp_pkg::CFG_STATUS_TYPE: reg_status_type = v;
                ksfp_pkg::CFG_AUTH_LIMIT:  reg_auth_limit = v;
                ksfp_pkg::CFG_ZONE_LIMIT:  reg_zone_limit = v;
                default: ;
            endcase
        endfunction

        function void rehunt(logic [7:0] b);
            body_len = '0;
            body_idx = '0;
            crc_acc = ksfp_pkg::CRC_INIT;
            crc_rx = '0;
            if (b == reg_head_first) phase = ksfp_pkg::PH_HEAD1;
            else phase = ksfp_pkg::PH_HEAD0;
        endfunction

        function void note_byte(logic [7:0] b);
            t_frame_report r;
            logic [7:0] ang;
            case (phase)
                ksfp_pkg::PH_HEAD0: begin
                    if (b == reg_head_first) phase = ksfp_pkg::PH_HEAD1;
                end
                ksfp_pkg::PH_HEAD1: begin
                    if (b == reg_head_second) begin
                        crc_acc = ksfp_pkg::CRC_INIT;
                        phase = ksfp_pkg::PH_VERSION;
                    end else begin
                        rehunt(b);
                    end
                end
                ksfp_pkg::PH_VERSION: begin
                    if (b == reg_version) begin
                        crc_acc = crc_next(crc_acc, b);
                        phase = ksfp_pkg::PH_TYPE;
                    end else begin
                        rehunt(b);
                    end
                end
                ksfp_pkg::PH_TYPE: begin
                    msg_type = b;
                    crc_acc = crc_next(crc_acc, b);
                    phase = ksfp_pkg::PH_SEQ;
                end
                ksfp_pkg::PH_SEQ: begin
                    seq_byte = b;
                    crc_acc = crc_next(crc_acc, b);
                    phase = ksfp_pkg::PH_LENGTH;
                end
                ksfp_pkg::PH_LENGTH: begin
                    if (int'(b) <= ksfp_pkg::MAX_PAYLOAD) begin
                        body_len = b;
                        body_idx = '0;
                        crc_acc = crc_next(crc_acc, b);
                        if (b == 8'd0) phase = ksfp_pkg::PH_CRCLO;
                        else phase = ksfp_pkg::PH_BODY;
                    end else begin
                        rehunt(b);
                    end
                end
                ksfp_pkg::PH_BODY: begin
                    if (int'(body_idx) < ksfp_pkg::STATUS_LEN)
                        body[body_idx[ksfp_pkg::IDX_W-1:0]] = b;
                    body_idx = body_idx + 8'd1;
                    crc_acc = crc_next(crc_acc, b);
                    if (body_idx >= body_len) phase = ksfp_pkg::PH_CRCLO;
                end
                ksfp_pkg::PH_CRCLO: begin
                    crc_rx = {8'h00, b};
                    phase = ksfp_pkg::PH_CRCHI;
                end
                ksfp_pkg::PH_CRCHI: begin
                    crc_rx[15:8] = b;
                    r = '0;
                    if (crc_rx != crc_acc) begin
                        crc_errors = crc_errors + 32'd1;
                        r.status = ksfp_pkg::ST_CRC_BAD;
                    end else begin
                        ang = body[6];
                        if (msg_type == reg_status_type &&
                            int'(body_len) == ksfp_pkg::STATUS_LEN &&
                            body[0] <= ksfp_pkg::ID_MAX && body[1] <= reg_auth_limit &&
                            body[2] <= reg_zone_limit &&
                            (ang <= ksfp_pkg::ANGLE_POS_MAX ||
                             ang >= ksfp_pkg::ANGLE_NEG_MIN)) begin
                            status_frames = status_frames + 32'd1;
                            r.status = ksfp_pkg::ST_ACCEPTED;
                            r.remote_id = body[0][3:0];
                            r.auth_result = body[1];
                            r.zone_code = body[2];
                            r.event_code = body[3];
                            r.distance_mm = {body[5], body[4]};
                            r.angle_deg = ang;
                            r.state_flags = body[7];
                            r.signal_quality = body[8];
                        end else begin
                            r.status = ksfp_pkg::ST_IGNORED;
                        end
                    end
                    r.frame_seq = seq_byte;
                    r.crc_error_total = crc_errors;
                    r.status_total = status_frames;
                    pending.push_back(r);
                    rehunt(b);
                end
                default: rehunt(b);
            endcase
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(t_frame_report got);
            t_frame_report want;
            if (pending.size() == 0) begin
                $error("result beat with no frame pending");
                mismatches++;
                return;
            end
            want = pending.pop_front();
            field_check("frame_status", 32'(want.status), 32'(got.status));
            field_check("remote_id", 32'(want.remote_id), 32'(got.remote_id));
            field_check("auth_result", 32'(want.auth_result), 32'(got.auth_result));
            field_check("zone_code", 32'(want.zone_code), 32'(got.zone_code));
            field_check("event_code", 32'(want.event_code), 32'(got.event_code));
            field_check("distance_mm", 32'(want.distance_mm), 32'(got.distance_mm));
            field_check("angle_deg", 32'(want.angle_deg), 32'(got.angle_deg));
            field_check("state_flags", 32'(want.state_flags), 32'(got.state_flags));
            field_check("signal_quality", 32'(want.signal_quality),
                        32'(got.signal_quality));
            field_check("frame_sequence", 32'(want.frame_seq), 32'(got.frame_seq));
            field_check("crc_error_total", want.crc_error_total, got.crc_error_total);
            field_check("status_total", want.status_total, got.status_total);
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [ksfp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]                     i_cfg_data = '0;
    logic                           i_rx_valid = 1'b0;
    logic                           o_rx_ready;
    logic [7:0]                     i_rx_byte = '0;
    logic                           o_res_valid;
    logic                           i_res_ready = 1'b0;
    logic [1:0]                     o_frame_status;
    logic [3:0]                     o_remote_id;
    logic [7:0]                     o_auth_result;
    logic [7:0]                     o_zone_code;
    logic [7:0]                     o_event_code;
    logic [15:0]                    o_distance_mm;
    logic signed [7:0]              o_angle_deg;
    logic [7:0]                     o_state_flags;
    logic [7:0]                     o_signal_quality;
    logic [7:0]                     o_frame_sequence;
    logic [31:0]                    o_crc_error_total;
    logic [31:0]                    o_status_total;

    t_lock_frame_tracker sb;
    logic [7:0] byte_plan [$];
    logic [7:0] payload_q [$];
    int idle_max = 4;
    int bytes_sent = 0;
    int idle_cycles;

    key_status_frame_parser_crc16_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_rx_valid        (i_rx_valid),
        .o_rx_ready        (o_rx_ready),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_frame_status    (o_frame_status),
        .o_remote_id       (o_remote_id),
        .o_auth_result     (o_auth_result),
        .o_zone_code       (o_zone_code),
        .o_event_code      (o_event_code),
        .o_distance_mm     (o_distance_mm),
        .o_angle_deg       (o_angle_deg),
        .o_state_flags     (o_state_flags),
        .o_signal_quality  (o_signal_quality),
        .o_frame_sequence  (o_frame_sequence),
        .o_crc_error_total (o_crc_error_total),
        .o_status_total    (o_status_total)
    );

    always #6 i_clk = ~i_clk;

    // Frame around payload_q with the current head and version settings
    function automatic void plan_frame(logic [7:0] typ, logic [7:0] seq, bit crc_bad);
        logic [15:0] crc;
        logic [7:0] len;
        len = 8'(payload_q.size());
        byte_plan.push_back(sb.reg_head_first);
        byte_plan.push_back(sb.reg_head_second);
        byte_plan.push_back(sb.reg_version);
        byte_plan.push_back(typ);
        byte_plan.push_back(seq);
        byte_plan.push_back(len);
        crc = t_lock_frame_tracker::crc_next(ksfp_pkg::CRC_INIT, sb.reg_version);
        crc = t_lock_frame_tracker::crc_next(crc, typ);
        crc = t_lock_frame_tracker::crc_next(crc, seq);
        crc = t_lock_frame_tracker::crc_next(crc, len);
        foreach (payload_q[i]) begin
            byte_plan.push_back(payload_q[i]);
            crc = t_lock_frame_tracker::crc_next(crc, payload_q[i]);
        end
        if (crc_bad) crc = crc ^ (16'd1 << $urandom_range(0, 15));
        byte_plan.push_back(crc[7:0]);
        byte_plan.push_back(crc[15:8]);
    endfunction

    function automatic void stage_status_payload(bit break_field);
        logic [7:0] id, auth, zone, ang;
        int pick;
        id = 8'($urandom_range(0, 15));
        auth = 8'($urandom_range(0, sb.reg_auth_limit));
        zone = 8'($urandom_range(0, sb.reg_zone_limit));
        ang = 8'($urandom_range(0, 180) - 90);
        if ($urandom_range(0, 7) == 0)
            ang = $urandom_range(0, 1) ? ksfp_pkg::ANGLE_POS_MAX : ksfp_pkg::ANGLE_NEG_MIN;
        if (break_field) begin
            pick = $urandom_range(0, 3);
            if (pick == 1 && sb.reg_auth_limit != 8'hFF)
                auth = 8'($urandom_range(sb.reg_auth_limit + 1, 255));
            else if (pick == 2 && sb.reg_zone_limit != 8'hFF)
                zone = 8'($urandom_range(sb.reg_zone_limit + 1, 255));
            else if (pick == 0)
                id = 8'($urandom_range(16, 255));
            else
                ang = 8'($urandom_range(91, 165));
        end
        payload_q = {id, auth, zone, 8'($urandom), 8'($urandom), 8'($urandom), ang,
                     8'($urandom), 8'($urandom)};
    endfunction

    function automatic void plan_random_item();
        int kind;
        int n;
        logic [7:0] x;
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            stage_status_payload($urandom_range(0, 4) == 0);
            plan_frame(sb.reg_status_type, 8'($urandom), 1'b0);
        end else if (kind < 62) begin
            payload_q.delete();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, ksfp_pkg::MAX_PAYLOAD)
                                            : $urandom_range(0, 12);
            repeat (n) payload_q.push_back(8'($urandom));
            plan_frame($urandom_range(0, 1) ? sb.reg_status_type : 8'($urandom),
                       8'($urandom), 1'b0);
        end else if (kind < 76) begin
            stage_status_payload(1'b0);
            plan_frame(sb.reg_status_type, 8'($urandom), 1'b1);
        end else begin
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 6)) byte_plan.push_back(8'($urandom));
                1: begin
                    // broken second head, sometimes a repeated first head
                    byte_plan.push_back(sb.reg_head_first);
                    x = $urandom_range(0, 1) ? sb.reg_head_first : 8'($urandom);
                    byte_plan.push_back(x);
                end
                2: begin
                    byte_plan.push_back(sb.reg_head_first);
                    byte_plan.push_back(sb.reg_head_second);
                    x = $urandom_range(0, 1) ? sb.reg_head_first : 8'($urandom);
                    byte_plan.push_back(x);
                end
                default: begin
                    // length above the payload limit
                    byte_plan.push_back(sb.reg_head_first);
                    byte_plan.push_back(sb.reg_head_second);
                    byte_plan.push_back(sb.reg_version);
                    byte_plan.push_back(8'($urandom));
                    byte_plan.push_back(8'($urandom));
                    x = 8'($urandom_range(ksfp_pkg::MAX_PAYLOAD + 1, 255));
                    if ($urandom_range(0, 1) == 1 &&
                        int'(sb.reg_head_first) > ksfp_pkg::MAX_PAYLOAD)
                        x = sb.reg_head_first;
                    byte_plan.push_back(x);
                end
            endcase
        end
    endfunction

    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_plan();
        while (byte_plan.size() > 0) send_rx_byte(byte_plan.pop_front());
    endtask

    task automatic settle();
        i_rx_valid <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_beat(input logic [ksfp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input int ph);
        logic [7:0] v [6];
        case (ph)
            1: v = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF};
            2: v = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00};
            default: foreach (v[i]) v[i] = 8'($urandom);
        endcase
        cfg_beat(ksfp_pkg::CFG_HEAD_FIRST, v[0]);
        cfg_beat(ksfp_pkg::CFG_HEAD_SECOND, v[1]);
        cfg_beat(ksfp_pkg::CFG_VERSION, v[2]);
        cfg_beat(ksfp_pkg::CFG_STATUS_TYPE, v[3]);
        cfg_beat(ksfp_pkg::CFG_AUTH_LIMIT, v[4]);
        cfg_beat(ksfp_pkg::CFG_ZONE_LIMIT, v[5]);
        cfg_beat(CFG_SPARE_A, 8'($urandom));
        cfg_beat(CFG_SPARE_B, 8'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            sb.check_report({o_frame_status, o_remote_id, o_auth_result, o_zone_code,
                             o_event_code, o_distance_mm, o_angle_deg, o_state_flags,
                             o_signal_quality, o_frame_sequence, o_crc_error_total,
                             o_status_total});
        end
    end

    initial begin : result_sink
        int stall;
        do @(negedge i_clk); while (!i_rst_n);
        forever begin
            stall = $urandom_range(0, idle_max);
            if (stall > 0) begin
                i_res_ready <= 1'b0;
                do @(posedge i_clk); while (!o_res_valid);
                repeat (stall - 1) @(posedge i_clk);
                @(negedge i_clk);
            end
            i_res_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_res_valid && i_res_ready));
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial begin : stimulus
        int start_bytes;
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                settle();
                apply_settings(ph);
            end
            idle_max = (ph == 1) ? 0 : 4;
            start_bytes = bytes_sent;
            if (ph == 0) begin
                // all-extreme accepted status frame, then an empty frame of another type
                payload_q = {ksfp_pkg::ID_MAX, sb.reg_auth_limit, sb.reg_zone_limit, 8'hFF,
                             8'hFF, 8'hFF, ksfp_pkg::ANGLE_NEG_MIN, 8'h00, 8'hFF};
                plan_frame(sb.reg_status_type, 8'hFF, 1'b0);
                payload_q.delete();
                plan_frame(8'h00, 8'h00, 1'b0);
                drain_plan();
            end
            while (bytes_sent - start_bytes < 100) begin
                plan_random_item();
                drain_plan();
            end
        end
        settle();
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
